>>> design/uvs_pkg.sv
package uvs_pkg;

    localparam int ATAN_N = 24;
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [1:0] {
        REG_STACK_COUNT = 2'd0,
        REG_SLICE_COUNT = 2'd1,
        REG_RADIUS      = 2'd2
    } t_reg;

    typedef struct packed {
        logic [7:0]  stk;
        logic [7:0]  slc;
        logic        ok;
        logic        qp;
        logic [7:0]  rem_p;
        logic [7:0]  rem_t;
        logic [32:0] q_p;
        logic [32:0] q_t;
    } t_div;

    typedef struct packed {
        logic [7:0]         stk;
        logic [7:0]         slc;
        logic               ok;
        logic               qp;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [1:0]         quad_p;
        logic [1:0]         quad_t;
        logic signed [31:0] xp;
        logic signed [31:0] yp;
        logic signed [32:0] zp;
        logic signed [31:0] xt;
        logic signed [31:0] yt;
        logic signed [32:0] zt;
    } t_rot;

    typedef struct packed {
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic signed [16:0] pos_z;
        logic signed [15:0] nrm_x;
        logic signed [15:0] nrm_y;
        logic signed [15:0] nrm_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [15:0]        quad_first;
        logic [15:0]        quad_second;
        logic               quad_present;
        logic               in_range;
    } t_vtx;

endpackage

>>> design/uvs_div_cell.sv
module uvs_div_cell
    import uvs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_stack_count,
    input  logic [7:0] i_slice_count,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_div       i_word,
    output logic       o_valid,
    input  logic       i_ready,
    output t_div       o_word
);

    logic       r_valid;
    t_div       r_word;
    t_div       n_word;
    logic [8:0] w_tp;
    logic [8:0] w_tt;
    logic       w_bp;
    logic       w_bt;

    // one quotient bit per cell for both divisions
    always_comb begin
        w_tp = {i_word.rem_p, 1'b0};
        w_tt = {i_word.rem_t, 1'b0};
        w_bp = w_tp >= {1'b0, i_stack_count};
        w_bt = w_tt >= {1'b0, i_slice_count};
        n_word = i_word;
        n_word.rem_p = w_bp ? 8'(w_tp - {1'b0, i_stack_count}) : w_tp[7:0];
        n_word.rem_t = w_bt ? 8'(w_tt - {1'b0, i_slice_count}) : w_tt[7:0];
        n_word.q_p = {i_word.q_p[31:0], w_bp};
        n_word.q_t = {i_word.q_t[31:0], w_bt};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

>>> design/uvs_rot_cell.sv
module uvs_rot_cell
    import uvs_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_rot i_word,
    output logic o_valid,
    input  logic i_ready,
    output t_rot o_word
);

    localparam logic signed [32:0] ATAN = $signed({1'b0, ATAN_TURNS[STAGE]});

    logic r_valid;
    t_rot r_word;
    t_rot n_word;

    // one rotation step for the polar and the azimuth angle
    always_comb begin
        n_word = i_word;
        if (i_word.zp >= 0) begin
            n_word.xp = i_word.xp - (i_word.yp >>> STAGE);
            n_word.yp = i_word.yp + (i_word.xp >>> STAGE);
            n_word.zp = i_word.zp - ATAN;
        end else begin
            n_word.xp = i_word.xp + (i_word.yp >>> STAGE);
            n_word.yp = i_word.yp - (i_word.xp >>> STAGE);
            n_word.zp = i_word.zp + ATAN;
        end
        if (i_word.zt >= 0) begin
            n_word.xt = i_word.xt - (i_word.yt >>> STAGE);
            n_word.yt = i_word.yt + (i_word.xt >>> STAGE);
            n_word.zt = i_word.zt - ATAN;
        end else begin
            n_word.xt = i_word.xt + (i_word.yt >>> STAGE);
            n_word.yt = i_word.yt - (i_word.xt >>> STAGE);
            n_word.zt = i_word.zt + ATAN;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

>>> design/uvs_post.sv
module uvs_post
    import uvs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_radius,
    input  logic [7:0]  i_slice_count,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_rot        i_word,
    output logic        o_valid,
    input  logic        i_ready,
    output t_vtx        o_word
);

    // stage a: quadrant fold and products
    logic               r_a_valid;
    logic [7:0]         r_a_stk;
    logic [7:0]         r_a_slc;
    logic               r_a_ok;
    logic               r_a_qp;
    logic [16:0]        r_a_tex_u;
    logic [16:0]        r_a_tex_v;
    logic signed [63:0] r_a_px;
    logic signed [63:0] r_a_pz;
    logic signed [31:0] r_a_cp;
    // stage b: rounding, normals, radius products, quad indices
    logic               r_b_valid;
    logic               r_b_ok;
    logic               r_b_qp;
    logic [16:0]        r_b_tex_u;
    logic [16:0]        r_b_tex_v;
    logic signed [50:0] r_b_p [3];
    logic signed [15:0] r_b_n [3];
    logic [15:0]        r_b_qf;
    logic [15:0]        r_b_qs;
    // stage c: output register
    logic               r_c_valid;
    t_vtx               r_c_word;

    logic               w_rdy_a;
    logic               w_rdy_b;
    logic               w_rdy_c;
    logic signed [31:0] w_cp;
    logic signed [31:0] w_sp;
    logic signed [31:0] w_ct;
    logic signed [31:0] w_st;
    logic signed [63:0] w_rx;
    logic signed [63:0] w_rz;
    logic signed [33:0] w_v [3];
    logic signed [33:0] w_nr [3];
    logic signed [15:0] n_b_n [3];
    logic signed [50:0] n_b_p [3];
    logic [8:0]         w_row;
    logic [16:0]        w_qf;
    logic [16:0]        w_qs;
    logic signed [50:0] w_pr [3];
    logic signed [16:0] w_ps [3];
    t_vtx               n_c_word;

    always_comb begin
        case (i_word.quad_p)
            2'd0: begin w_cp = i_word.xp;  w_sp = i_word.yp;  end
            2'd1: begin w_cp = -i_word.yp; w_sp = i_word.xp;  end
            2'd2: begin w_cp = -i_word.xp; w_sp = -i_word.yp; end
            default: begin w_cp = i_word.yp; w_sp = -i_word.xp; end
        endcase
        case (i_word.quad_t)
            2'd0: begin w_ct = i_word.xt;  w_st = i_word.yt;  end
            2'd1: begin w_ct = -i_word.yt; w_st = i_word.xt;  end
            2'd2: begin w_ct = -i_word.xt; w_st = -i_word.yt; end
            default: begin w_ct = i_word.yt; w_st = -i_word.xt; end
        endcase
    end

    always_comb begin
        w_rx = (r_a_px + 64'sd536870912) >>> 30;
        w_rz = (r_a_pz + 64'sd536870912) >>> 30;
        w_v[0] = w_rx[33:0];
        w_v[1] = 34'(r_a_cp);
        w_v[2] = w_rz[33:0];
        for (int k = 0; k < 3; k++) begin
            w_nr[k] = (w_v[k] + 34'sd16384) >>> 15;
            if (w_nr[k] > 34'sd32767) begin
                n_b_n[k] = 16'sd32767;
            end else if (w_nr[k] < -34'sd32767) begin
                n_b_n[k] = -16'sd32767;
            end else begin
                n_b_n[k] = w_nr[k][15:0];
            end
            n_b_p[k] = 51'(w_v[k]) * $signed({35'd0, i_radius});
        end
        w_row = {1'b0, i_slice_count} + 9'd1;
        w_qf = 17'(r_a_stk) * 17'(w_row) + 17'(r_a_slc);
        w_qs = 17'({1'b0, r_a_stk} + 9'd1) * 17'(w_row) + 17'(r_a_slc);
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_pr[k] = (r_b_p[k] + 51'sd536870912) >>> 30;
            if (w_pr[k] > 51'sd65535) begin
                w_ps[k] = 17'sd65535;
            end else if (w_pr[k] < -51'sd65535) begin
                w_ps[k] = -17'sd65535;
            end else begin
                w_ps[k] = w_pr[k][16:0];
            end
        end
        n_c_word = '0;
        if (r_b_ok) begin
            n_c_word.pos_x = w_ps[0];
            n_c_word.pos_y = w_ps[1];
            n_c_word.pos_z = w_ps[2];
            n_c_word.nrm_x = r_b_n[0];
            n_c_word.nrm_y = r_b_n[1];
            n_c_word.nrm_z = r_b_n[2];
            n_c_word.tex_u = r_b_tex_u;
            n_c_word.tex_v = r_b_tex_v;
            n_c_word.in_range = 1'b1;
            if (r_b_qp) begin
                n_c_word.quad_first   = r_b_qf;
                n_c_word.quad_second  = r_b_qs;
                n_c_word.quad_present = 1'b1;
            end
        end
    end

    assign w_rdy_c = !r_c_valid || i_ready;
    assign w_rdy_b = !r_b_valid || w_rdy_c;
    assign w_rdy_a = !r_a_valid || w_rdy_b;
    assign o_ready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_rdy_a) r_a_valid <= i_valid;
            if (w_rdy_b) r_b_valid <= r_a_valid;
            if (w_rdy_c) r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_a_stk   <= i_word.stk;
            r_a_slc   <= i_word.slc;
            r_a_ok    <= i_word.ok;
            r_a_qp    <= i_word.qp;
            r_a_tex_u <= i_word.tex_u;
            r_a_tex_v <= i_word.tex_v;
            r_a_px    <= 64'(w_sp) * 64'(w_ct);
            r_a_pz    <= 64'(w_sp) * 64'(w_st);
            r_a_cp    <= w_cp;
        end
        if (w_rdy_b && r_a_valid) begin
            r_b_ok    <= r_a_ok;
            r_b_qp    <= r_a_qp;
            r_b_tex_u <= r_a_tex_u;
            r_b_tex_v <= r_a_tex_v;
            r_b_p     <= n_b_p;
            r_b_n     <= n_b_n;
            r_b_qf    <= w_qf[15:0];
            r_b_qs    <= w_qs[15:0];
        end
        if (w_rdy_c && r_b_valid) begin
            r_c_word <= n_c_word;
        end
    end

    assign o_valid = r_c_valid;
    assign o_word  = r_c_word;

endmodule

>>> design/uv_sphere_vertex_generator.sv
// an accepted word passes the divider cells, rotation cells and post stages a, b, c
// throughput: one word per cycle without stalls, each stage a register cell with a valid
// a stalled output only holds back cells that are full, bubbles still fill behind it
// reset: stack_count 16, slice_count 32, sphere_radius 1.0, all cells emptied
module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // stack_index[7:0], slice_index[15:8]
    input  logic [15:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v,
    // quad_first, quad_second, zero pad
    output logic [167:0] m_axis_tdata,
    // quad_present, in_range
    output logic [1:0]   m_axis_tuser
);

    localparam int DIV_CELLS = 32;

    logic [7:0]  r_stack_count;
    logic [7:0]  r_slice_count;
    logic [15:0] r_radius;
    t_reg        w_reg;

    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_count <= 8'd16;
            r_slice_count <= 8'd32;
            r_radius      <= 16'd256;
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg)
                REG_STACK_COUNT: r_stack_count <= pwdata[7:0];
                REG_SLICE_COUNT: r_slice_count <= pwdata[7:0];
                REG_RADIUS:      r_radius      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_STACK_COUNT: prdata = {24'd0, r_stack_count};
            REG_SLICE_COUNT: prdata = {24'd0, r_slice_count};
            REG_RADIUS:      prdata = {16'd0, r_radius};
            default:         prdata = '0;
        endcase
    end

    t_div w_div   [DIV_CELLS+1];
    logic v_div   [DIV_CELLS+1];
    logic rdy_div [DIV_CELLS+1];
    t_rot w_rot   [CORDIC_STAGES+1];
    logic v_rot   [CORDIC_STAGES+1];
    logic rdy_rot [CORDIC_STAGES+1];
    logic [7:0]  w_stk;
    logic [7:0]  w_slc;
    logic        w_bp;
    logic        w_bt;
    logic [31:0] w_ph;
    logic [31:0] w_th;
    t_vtx        w_out;

    // entry: top quotient bit, range flags
    always_comb begin
        w_stk = s_axis_tdata[7:0];
        w_slc = s_axis_tdata[15:8];
        w_bp  = w_stk >= r_stack_count;
        w_bt  = w_slc >= r_slice_count;
        w_div[0].stk   = w_stk;
        w_div[0].slc   = w_slc;
        w_div[0].ok    = (r_stack_count != 8'd0) && (r_slice_count != 8'd0)
                         && (w_stk <= r_stack_count) && (w_slc <= r_slice_count);
        w_div[0].qp    = (w_stk < r_stack_count) && (w_slc < r_slice_count);
        w_div[0].rem_p = w_bp ? 8'(w_stk - r_stack_count) : w_stk;
        w_div[0].rem_t = w_bt ? 8'(w_slc - r_slice_count) : w_slc;
        w_div[0].q_p   = {32'd0, w_bp};
        w_div[0].q_t   = {32'd0, w_bt};
    end
    assign v_div[0]      = s_axis_tvalid;
    assign s_axis_tready = rdy_div[0];

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
        uvs_div_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_stack_count (r_stack_count),
            .i_slice_count (r_slice_count),
            .i_valid       (v_div[k]),
            .o_ready       (rdy_div[k]),
            .i_word        (w_div[k]),
            .o_valid       (v_div[k+1]),
            .i_ready       (rdy_div[k+1]),
            .o_word        (w_div[k+1])
        );
    end

    // quotient to phases and texture coordinates
    always_comb begin
        w_ph = w_div[DIV_CELLS].q_p[32:1];
        w_th = w_div[DIV_CELLS].q_t[31:0];
        w_rot[0].stk    = w_div[DIV_CELLS].stk;
        w_rot[0].slc    = w_div[DIV_CELLS].slc;
        w_rot[0].ok     = w_div[DIV_CELLS].ok;
        w_rot[0].qp     = w_div[DIV_CELLS].qp;
        w_rot[0].tex_u  = w_div[DIV_CELLS].q_t[32:16];
        w_rot[0].tex_v  = w_div[DIV_CELLS].q_p[32:16];
        w_rot[0].quad_p = w_ph[31:30];
        w_rot[0].quad_t = w_th[31:30];
        w_rot[0].xp     = GAIN_Q30;
        w_rot[0].yp     = '0;
        w_rot[0].zp     = {3'd0, w_ph[29:0]};
        w_rot[0].xt     = GAIN_Q30;
        w_rot[0].yt     = '0;
        w_rot[0].zt     = {3'd0, w_th[29:0]};
    end
    assign v_rot[0]           = v_div[DIV_CELLS];
    assign rdy_div[DIV_CELLS] = rdy_rot[0];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
        uvs_rot_cell #(
            .STAGE (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_rot[k]),
            .o_ready (rdy_rot[k]),
            .i_word  (w_rot[k]),
            .o_valid (v_rot[k+1]),
            .i_ready (rdy_rot[k+1]),
            .o_word  (w_rot[k+1])
        );
    end

    uvs_post u_post (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_radius      (r_radius),
        .i_slice_count (r_slice_count),
        .i_valid       (v_rot[CORDIC_STAGES]),
        .o_ready       (rdy_rot[CORDIC_STAGES]),
        .i_word        (w_rot[CORDIC_STAGES]),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_word        (w_out)
    );

    assign m_axis_tdata = {3'd0, w_out.quad_second, w_out.quad_first, w_out.tex_v,
                           w_out.tex_u, w_out.nrm_z, w_out.nrm_y, w_out.nrm_x,
                           w_out.pos_z, w_out.pos_y, w_out.pos_x};
    assign m_axis_tuser = {w_out.in_range, w_out.quad_present};

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_out.in_range |-> m_axis_tdata == '0)
        else $error("out of range word carries data");

    a_quad_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_out.quad_present |-> w_out.in_range)
        else $error("quad flagged outside grid");

    a_no_quad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_out.quad_present
        |-> w_out.quad_first == '0 && w_out.quad_second == '0)
        else $error("quad indices without quad");

    a_normal_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_out.nrm_y != 16'sh8000)
        else $error("normal not saturated");

endmodule

>>> bench/uv_sphere_vertex_generator_tb.sv
`timescale 1ns / 100ps

module uv_sphere_vertex_generator_tb;
    import uvs_pkg::*;

    localparam int          STAGES        = 16;
    localparam int          LATENCY       = 35 + STAGES;
    localparam int          STALL_LIMIT   = 4000;
    localparam logic [3:0]  ADDR_UNMAPPED = 4'd12;

    class vertex_scoreboard;
        t_vtx        pending_vtx[$];
        logic [7:0]  n_stacks;
        logic [7:0]  n_slices;
        logic [15:0] radius;
        int          mismatches;
        int          words_in;
        int          words_out;

        function void set_reg(logic [3:0] addr, logic [31:0] val);
            case (addr)
                4'(REG_STACK_COUNT) * 4: n_stacks = val[7:0];
                4'(REG_SLICE_COUNT) * 4: n_slices = val[7:0];
                4'(REG_RADIUS) * 4:      radius   = val[15:0];
                default: ;
            endcase
        endfunction

        function longint rshift_round(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function longint clamp(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function void sin_cos(logic [31:0] ph, output longint c, output longint s);
            longint x, y, z, dx, dy;
            x = longint'(GAIN_Q30);
            y = 0;
            z = longint'({34'd0, ph[29:0]});
            for (int i = 0; i < STAGES && i < ATAN_N; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - longint'({32'd0, ATAN_TURNS[i]});
                end else begin
                    x = x + dx; y = y - dy; z = z + longint'({32'd0, ATAN_TURNS[i]});
                end
            end
            case (ph[31:30])
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function void note_point(logic [7:0] stk, logic [7:0] slc);
            t_vtx        e;
            longint      cp, sp, ct, st, p, n;
            longint      dir[3];
            logic [63:0] ph_phi, ph_th, row;
            e = '0;
            words_in++;
            if (n_stacks != 0 && n_slices != 0 && stk <= n_stacks && slc <= n_slices) begin
                ph_phi = ({56'd0, stk} << 31) / n_stacks;
                ph_th  = ({56'd0, slc} << 32) / n_slices;
                sin_cos(ph_phi[31:0], cp, sp);
                sin_cos(ph_th[31:0], ct, st);
                dir[0] = rshift_round(sp * ct, 30);
                dir[1] = cp;
                dir[2] = rshift_round(sp * st, 30);
                for (int k = 0; k < 3; k++) begin
                    p = clamp(rshift_round(dir[k] * longint'({48'd0, radius}), 30), 65535);
                    n = clamp(rshift_round(dir[k], 15), 32767);
                    case (k)
                        0: begin e.pos_x = p[16:0]; e.nrm_x = n[15:0]; end
                        1: begin e.pos_y = p[16:0]; e.nrm_y = n[15:0]; end
                        default: begin e.pos_z = p[16:0]; e.nrm_z = n[15:0]; end
                    endcase
                end
                e.tex_u = 17'((({56'd0, slc} << 16) / n_slices));
                e.tex_v = 17'((({56'd0, stk} << 16) / n_stacks));
                if (stk < n_stacks && slc < n_slices) begin
                    row = {56'd0, n_slices} + 1;
                    e.quad_first   = 16'({56'd0, stk} * row + slc);
                    e.quad_second  = 16'(({56'd0, stk} + 1) * row + slc);
                    e.quad_present = 1'b1;
                end
                e.in_range = 1'b1;
            end
            pending_vtx = {pending_vtx, e};
        endfunction

        function void check_vertex(logic [167:0] d, logic [1:0] u);
            t_vtx a, e;
            words_out++;
            a.pos_x        = d[16:0];
            a.pos_y        = d[33:17];
            a.pos_z        = d[50:34];
            a.nrm_x        = d[66:51];
            a.nrm_y        = d[82:67];
            a.nrm_z        = d[98:83];
            a.tex_u        = d[115:99];
            a.tex_v        = d[132:116];
            a.quad_first   = d[148:133];
            a.quad_second  = d[164:149];
            a.quad_present = u[0];
            a.in_range     = u[1];
            if (pending_vtx.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: %p", a);
                return;
            end
            e = pending_vtx.pop_front();
            if (a !== e || d[167:165] !== 3'd0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at word %0d", words_out);
                    $display("  expected %p", e);
                    $display("  actual   %p", a);
                end
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         psel, penable, pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid, s_axis_tready;
    logic [15:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    vertex_scoreboard sb;
    int src_idle;
    int sink_stall;
    int quiet_cycles = 0;
    bit running;

    uv_sphere_vertex_generator #(.CORDIC_STAGES(STAGES)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_point(s_axis_tdata[7:0], s_axis_tdata[15:8]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_vertex(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || !running)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** uv_sphere_vertex_generator: FAILED **");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(addr, val);
    endtask

    task automatic send_point(input logic [7:0] stk, input logic [7:0] slc);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {slc, stk};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        running = 1'b1;
        while (sb.pending_vtx.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        running = 1'b0;
    endtask

    task automatic random_point(output logic [7:0] stk, output logic [7:0] slc);
        if ($urandom_range(9) < 8) begin
            stk = 8'($urandom_range(int'(sb.n_stacks) + 1 > 255 ? 255 : sb.n_stacks + 1));
            slc = 8'($urandom_range(int'(sb.n_slices) + 1 > 255 ? 255 : sb.n_slices + 1));
        end else begin
            stk = 8'($urandom_range(255));
            slc = 8'($urandom_range(255));
        end
    endtask

    initial begin
        logic [7:0]  stk, slc;
        logic [31:0] cfg[9][3];
        int          idles[4][2];
        sb = new();
        sb.n_stacks = 8'd16; sb.n_slices = 8'd32; sb.radius = 16'd256;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        src_idle = 0; sink_stall = 0; running = 1'b0;
        idles = '{'{0, 0}, '{82, 0}, '{0, 82}, '{31, 31}};
        cfg = '{'{16, 32, 256}, '{1, 1, 65535}, '{255, 255, 0}, '{0, 5, 100},
                '{7, 0, 300}, '{3, 4, 32'hFFFF}, '{255, 1, 65535}, '{12, 200, 1},
                '{$urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(65535)}};
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults from reset, corners of the grid, then random points for every register setting
        running = 1'b1;
        foreach (cfg[p]) begin
            if (p > 0) begin
                apb_write(4'(REG_STACK_COUNT) * 4, cfg[p][0]);
                apb_write(4'(REG_SLICE_COUNT) * 4, cfg[p][1]);
                apb_write(4'(REG_RADIUS) * 4, cfg[p][2]);
                apb_write(ADDR_UNMAPPED, $urandom);
            end
            src_idle   = idles[p % 4][0];
            sink_stall = idles[p % 4][1];
            running = 1'b1;
            if (p == 0) begin
                for (int a = 0; a < 5; a++) begin
                    for (int b = 0; b < 5; b++) begin
                        stk = (a == 0) ? 8'd0 : (a == 1) ? 8'd8 : (a == 2) ? 8'd15 :
                              (a == 3) ? 8'd16 : 8'd255;
                        slc = (b == 0) ? 8'd0 : (b == 1) ? 8'd31 : (b == 2) ? 8'd32 :
                              (b == 3) ? 8'd33 : 8'd255;
                        send_point(stk, slc);
                    end
                end
            end
            for (int n = 0; n < 160; n++) begin
                if (p == 2 && n == 80) drain();
                running = 1'b1;
                random_point(stk, slc);
                send_point(stk, slc);
            end
            drain();
        end

        $display("covered %0d grid points over %0d register settings", sb.words_in, 9);
        $display("including empty grids, unit grids, zero and full radius, four stall mixes");
        if (sb.mismatches == 0 && sb.pending_vtx.size() == 0 && sb.words_out == sb.words_in)
            $display("** uv_sphere_vertex_generator: PASSED **");
        else
            $display("** uv_sphere_vertex_generator: FAILED **");
        $finish;
    end
endmodule

>>> files.f
design/uvs_pkg.sv
design/uvs_div_cell.sv
design/uvs_rot_cell.sv
design/uvs_post.sv
design/uv_sphere_vertex_generator.sv
bench/uv_sphere_vertex_generator_tb.sv
